// File: design/number_to_english_word_tokens_assert.svh
// Assertion macros for the number-to-words token block.
`ifndef NUMBER_TO_ENGLISH_WORD_TOKENS_ASSERT_SVH
`define NUMBER_TO_ENGLISH_WORD_TOKENS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NWT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define NWT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/nwt_pkg.sv
// Types, token codes and helper functions for the number-to-words block.
`default_nettype none

package nwt_pkg;

   localparam int NUM_W    = 31;
   localparam int CODE_W   = 5;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int GROUPS   = 4;
   localparam int GSLOTS   = 5;
   localparam int SLOTS    = GROUPS * GSLOTS;
   localparam int DD_STAGES = 4;
   localparam int DD_STEPS = 8;

   typedef logic [NUM_W-1:0]  number_type;
   typedef logic [CODE_W-1:0] word_type;
   typedef logic [3:0]        digit_type;
   typedef logic [BCD_W-1:0]  bcd_type;

   localparam word_type CODE_ZERO      = 5'd0;
   localparam word_type CODE_TEN       = 5'd10;
   localparam word_type CODE_TENS_BASE = 5'd18;
   localparam word_type CODE_HUNDRED   = 5'd28;
   localparam word_type CODE_THOUSAND  = 5'd29;
   localparam word_type CODE_MILLION   = 5'd30;
   localparam word_type CODE_BILLION   = 5'd31;

   typedef struct packed {
      logic [GSLOTS-1:0][CODE_W-1:0] code;
      logic [GSLOTS-1:0]             vld;
   } group_slots_type;

   // One double-dabble step: add three to digits of five or more, shift in a bit.
   function automatic bcd_type dd_step(input bcd_type bcd, input logic bit_in);
      bcd_type adj;
      adj = bcd;
      for (int k = 0; k < DIGITS; k++) begin
         if (adj[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   // Word slots of one group: digit, Hundred, word, unit, scale.
   function automatic group_slots_type group_slots(input digit_type h, input digit_type t,
                                                   input digit_type u, input word_type scale,
                                                   input logic has_scale);
      group_slots_type g;
      g.code[0] = {1'b0, h};
      g.vld[0]  = (h != 4'd0);
      g.code[1] = CODE_HUNDRED;
      g.vld[1]  = (h != 4'd0);
      if (t == 4'd0) begin
         g.code[2] = {1'b0, u};
         g.vld[2]  = (u != 4'd0);
      end else if (t == 4'd1) begin
         g.code[2] = {1'b0, u} + CODE_TEN;
         g.vld[2]  = 1'b1;
      end else begin
         g.code[2] = {1'b0, t} + CODE_TENS_BASE;
         g.vld[2]  = 1'b1;
      end
      g.code[3] = {1'b0, u};
      g.vld[3]  = (t >= 4'd2) && (u != 4'd0);
      g.code[4] = scale;
      g.vld[4]  = has_scale && ((h | t | u) != 4'd0);
      return g;
   endfunction

endpackage

`default_nettype wire

// File: design/nwt_req_if.sv
// Request channel: valid/ready handshake carrying the number.
`default_nettype none

interface nwt_req_if
   import nwt_pkg::*;
();
   logic       valid;
   logic       ready;
   number_type number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// File: design/nwt_rsp_if.sv
// Response channel: valid/ready handshake carrying one word token.
`default_nettype none

interface nwt_rsp_if
   import nwt_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type word_code;
   logic     last_word;

   modport source (output valid, output word_code, output last_word, input ready);
   modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

// File: design/number_to_english_word_tokens.sv
// Number to English word tokens: pipelined BCD conversion and token serializer.
//
// Usage:
//   req_ch carries one 31-bit unsigned number per request (valid/ready).
//   rsp_ch returns the English reading as word token codes, one per request
//   on that channel, with last_word set on the final token of each number.
//   Codes: 0-19 Zero..Nineteen, 20-27 Twenty..Ninety, 28 Hundred,
//   29 Thousand, 30 Million, 31 Billion. Zero yields the single token Zero.
// Pipeline: an accepted number passes four double-dabble stages, one slot-building
//   stage, the serializer load and the response register before its first token is valid.
// Throughput: one token per cycle while rsp_ch.ready holds; a number yields 1 to 16
//   tokens, since the serializer feeds the single response register.
//   The serializer loads the next number in the cycle it hands over the last
//   token of the current one, so back-to-back numbers leave no gaps.
// Reset (synchronous, active high) empties the pipeline, the serializer and
//   the response register. A stalled receiver holds the response register;
//   the pipeline keeps filling until its five stages are full, then
//   req_ch.ready drops. Nothing is lost or repeated.
`default_nettype none

module number_to_english_word_tokens
   import nwt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   nwt_req_if.sink   req_ch,
   nwt_rsp_if.source rsp_ch
);

   `include "number_to_english_word_tokens_assert.svh"

   // ---------------------------------------------------------------------
   // Stages 0..3: binary to BCD, eight shift steps per stage (seven last).
   // ---------------------------------------------------------------------
   logic    [DD_STAGES:0] v_ff;          // valid per stage, index 4 = slot stage
   logic    [DD_STAGES:0] adv;           // stage may load
   bcd_type               bcd_ff [DD_STAGES];
   number_type            bin_ff [DD_STAGES];
   bcd_type               bcd_in [DD_STAGES];
   number_type            bin_in [DD_STAGES];

   // Slot stage
   logic [SLOTS-1:0][CODE_W-1:0] slot_code_ff, slot_code_in;
   logic [SLOTS-1:0]             slot_mask_ff, slot_mask_in;

   // Serializer
   logic [SLOTS-1:0][CODE_W-1:0] ser_code_ff;
   logic [SLOTS-1:0]             ser_mask_ff, ser_mask_in;
   logic [SLOTS-1:0]             ser_sel, ser_rest;
   word_type                     ser_word;
   logic                         ser_emit, ser_take, ser_load;

   // Response register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_word_ff;
   logic     rsp_last_ff;

   generate
      for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
         localparam int STEPS = (s == DD_STAGES - 1) ? NUM_W - DD_STEPS * (DD_STAGES - 1)
                                                     : DD_STEPS;
         bcd_type    bcd_src;
         number_type bin_src;

         // First stage starts from the raw number, later ones from the stage before.
         if (s == 0) begin : g_head
            assign bcd_src = '0;
            assign bin_src = req_ch.number;
         end else begin : g_tail
            assign bcd_src = bcd_ff[s-1];
            assign bin_src = bin_ff[s-1];
         end

         always_comb begin
            bcd_type    bcd;
            number_type bin;
            bcd = bcd_src;
            bin = bin_src;
            for (int j = 0; j < STEPS; j++) begin
               bcd = dd_step(bcd, bin[NUM_W-1]);
               bin = {bin[NUM_W-2:0], 1'b0};
            end
            bcd_in[s] = bcd;
            bin_in[s] = bin;
         end

         always_ff @(posedge clock) begin
            if (adv[s]) begin
               bcd_ff[s] <= bcd_in[s];
               bin_ff[s] <= bin_in[s];
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Stage 4: word slots, five per group (billions, millions, thousands, units).
   // ---------------------------------------------------------------------
   always_comb begin
      group_slots_type g_bil, g_mil, g_tho, g_uni;
      bcd_type         b;
      b     = bcd_ff[DD_STAGES-1];
      // Billions group has one digit only: the number stays below 2^31.
      g_bil = group_slots(4'd0, 4'd0, b[39:36], CODE_BILLION, 1'b1);
      g_mil = group_slots(b[35:32], b[31:28], b[27:24], CODE_MILLION, 1'b1);
      g_tho = group_slots(b[23:20], b[19:16], b[15:12], CODE_THOUSAND, 1'b1);
      g_uni = group_slots(b[11:8], b[7:4], b[3:0], CODE_ZERO, 1'b0);
      slot_code_in = {g_uni.code, g_tho.code, g_mil.code, g_bil.code};
      slot_mask_in = {g_uni.vld, g_tho.vld, g_mil.vld, g_bil.vld};
      // Zero alone reads as the single word Zero.
      if (b == '0) begin
         slot_code_in[0] = CODE_ZERO;
         slot_mask_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DD_STAGES]) begin
         slot_code_ff <= slot_code_in;
         slot_mask_ff <= slot_mask_in;
      end
   end

   // ---------------------------------------------------------------------
   // Serializer: pick the lowest pending slot each cycle the output frees up.
   // ---------------------------------------------------------------------
   always_comb begin
      ser_sel  = ser_mask_ff & (~ser_mask_ff + {{(SLOTS-1){1'b0}}, 1'b1});
      ser_rest = ser_mask_ff & ~ser_sel;
      ser_word = '0;
      for (int k = 0; k < SLOTS; k++) begin
         ser_word = ser_word | (ser_code_ff[k] & {CODE_W{ser_sel[k]}});
      end
      ser_emit = (ser_mask_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);
      ser_take = (ser_mask_ff == '0) || (ser_emit && (ser_rest == '0));
      ser_load = v_ff[DD_STAGES] && ser_take;
      if (ser_load) begin
         ser_mask_in = slot_mask_ff;
      end else if (ser_emit) begin
         ser_mask_in = ser_rest;
      end else begin
         ser_mask_in = ser_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_code_ff <= slot_code_ff;
      end
   end

   // Stage handshake: a stage loads when empty or when its content moves on.
   always_comb begin
      adv[DD_STAGES] = !v_ff[DD_STAGES] || ser_take;
      for (int s = DD_STAGES - 1; s >= 0; s--) begin
         adv[s] = !v_ff[s] || adv[s+1];
      end
   end

   assign req_ch.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= '0;
         ser_mask_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_ch.valid;
         end
         for (int s = 1; s <= DD_STAGES; s++) begin
            if (adv[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
         ser_mask_ff <= ser_mask_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_comb begin
      if (ser_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_emit) begin
         rsp_word_ff <= ser_word;
         rsp_last_ff <= (ser_rest == '0);
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.word_code = rsp_word_ff;
   assign rsp_ch.last_word = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Every number reaching the slot stage has at least one word.
   `NWT_ASSERT_NOW(a_slot_nonempty, v_ff[DD_STAGES], slot_mask_ff != '0,
      "slot stage holds a request with no words")
   // The longest reading has sixteen words.
   `NWT_ASSERT_NOW(a_ser_max_words, 1'b1, $countones(ser_mask_ff) <= 16,
      "serializer holds more than sixteen words")
   // The serializer fills only from the slot stage.
   `NWT_ASSERT_NEXT(a_ser_fill_src, (ser_mask_ff == '0) && !v_ff[DD_STAGES],
      ser_mask_ff == '0, "serializer filled without a request from the slot stage")

endmodule

`default_nettype wire

// File: tb/number_to_english_word_tokens_tb.sv
// Testbench for number_to_english_word_tokens: random and directed numbers, token scoreboard.
`default_nettype none

module number_to_english_word_tokens_tb;
   import nwt_pkg::*;

   localparam int RANDOM_ITEMS   = 330;
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off, fills the pipeline
   localparam int WATCHDOG_LIMIT = 2000;  // idle cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 20;    // longer than the pipeline latency, catches stray tokens
   localparam int REPORT_LIMIT   = 10;

   // One expected word token, tagged with the number it came from.
   typedef struct {
      number_type number;
      word_type   code;
      logic       last;
   } word_token_type;

   // Predicts the token run of each accepted request and checks tokens in order.
   class word_scoreboard_type;
      word_token_type expected_words[$];
      word_type       reading[$];
      int             mismatches;

      function void add_word(word_type code);
         reading.insert(reading.size(), code);
      endfunction

      // Digit + Hundred, then teen/unit word or tens (+ unit), then scale.
      function void read_group(int unsigned grp, word_type scale, bit has_scale);
         int unsigned hund;
         int unsigned rest;
         hund = grp / 100;
         rest = grp % 100;
         if (grp == 0) return;
         if (hund != 0) begin
            add_word(word_type'(hund));
            add_word(CODE_HUNDRED);
         end
         if (rest != 0 && rest <= 19) begin
            add_word(word_type'(rest));
         end else if (rest >= 20) begin
            add_word(CODE_TENS_BASE + word_type'(rest / 10));
            if (rest % 10 != 0) add_word(word_type'(rest % 10));
         end
         if (has_scale) add_word(scale);
      endfunction

      function void note_number(number_type number);
         int unsigned remain;
         remain = number;
         reading.delete();
         if (remain == 0) begin
            add_word(CODE_ZERO);
         end else begin
            read_group(remain / 1000000000, CODE_BILLION, 1'b1);
            remain = remain % 1000000000;
            read_group(remain / 1000000, CODE_MILLION, 1'b1);
            remain = remain % 1000000;
            read_group(remain / 1000, CODE_THOUSAND, 1'b1);
            read_group(remain % 1000, CODE_ZERO, 1'b0);
         end
         foreach (reading[i]) begin
            expected_words.insert(expected_words.size(),
                                  word_token_type'{number, reading[i],
                                                   i == reading.size() - 1});
         end
      endfunction

      function void check_word(word_type code, logic last);
         word_token_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected token: code %0d last %0b", code, last);
            return;
         end
         want = expected_words.pop_front();
         if (code !== want.code || last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("number %0d: expected code %0d last %0b, got code %0d last %0b",
                        want.number, want.code, want.last, code, last);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   nwt_req_if req_bus ();
   nwt_rsp_if rsp_bus ();

   number_to_english_word_tokens DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   word_scoreboard_type word_board = new();

   // steady: no idling on either side. hold_words: receiver parks ready low.
   bit steady;
   bit hold_words;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or a few cycles, now and then a long one.
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // One group below a thousand, biased toward the interesting shapes.
   function automatic int unsigned random_group();
      case ($urandom_range(0, 6))
         0, 1: return 0;
         2: return 100 * $urandom_range(1, 9);
         3: return $urandom_range(10, 19);
         4: return 10 * $urandom_range(2, 9);
         default: return $urandom_range(1, 999);
      endcase
   endfunction

   // Mix of full-range, small and group-structured numbers.
   function automatic number_type random_number();
      longint unsigned value;
      case ($urandom_range(0, 9))
         0, 1, 2: return number_type'($urandom());
         3, 4: return number_type'($urandom_range(0, 999));
         5: return number_type'($urandom_range(0, 120));
         default: begin
            value = longint'($urandom_range(0, 2)) * 1000000000
                  + longint'(random_group()) * 1000000
                  + longint'(random_group()) * 1000
                  + longint'(random_group());
            if (value > 64'd2147483647) value = value - 1000000000;
            return number_type'(value);
         end
      endcase
   endfunction

   // Offer one number and hold it until the block takes it. valid stays high
   // into the next request when no gap follows, so it is never lowered and
   // raised in the same step.
   task automatic offer_number(number_type value);
      int gap;
      req_bus.valid  <= 1'b1;
      req_bus.number <= value;
      do @(posedge clock); while (!req_bus.ready);
      gap = steady ? 0 : random_gap();
      if (gap > 0) begin
         req_bus.valid  <= 1'b0;
         req_bus.number <= number_type'($urandom());
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender pause: nothing offered until every expected token has come back.
   task automatic wait_words_drained();
      req_bus.valid <= 1'b0;
      while (word_board.pending() != 0) @(posedge clock);
   endtask

   task automatic offer_random(int count);
      repeat (count) offer_number(random_number());
   endtask

   // Receiver: random stalls, idle-free stretches, and one long hold-off.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_words) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_words = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = random_gap();
         end
      end
   end

   // Handshakes are sampled at the edge; all drivers use nonblocking updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) word_board.note_number(req_bus.number);
         if (rsp_bus.valid && rsp_bus.ready)
            word_board.check_word(rsp_bus.word_code, rsp_bus.last_word);
      end
   end

   // Watchdog: counts cycles with no handshake on either channel.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d tokens outstanding",
               WATCHDOG_LIMIT, word_board.pending());
      $display("** number_to_english_word_tokens: FAILED **");
      $finish;
   end

   // Main sequence.
   initial begin
      number_type directed_numbers[$];
      directed_numbers = '{
         0, 1, 7, 10, 11, 15, 19, 20, 21, 45, 99, 100, 101, 110, 999,
         1000, 1001, 12345, 1000000, 1000010, 1000000000, 1002003004,
         2000000000, 2147483646, 2147483647
      };
      steady         = 1'b0;
      hold_words     = 1'b0;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.number <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, teens, tens, hundreds, every scale, the longest reading.
      foreach (directed_numbers[i]) offer_number(directed_numbers[i]);

      // Random with gaps on both sides.
      offer_random(120);

      // Back-to-back stretch with no idling anywhere.
      steady = 1'b1;
      offer_random(60);
      steady = 1'b0;

      // Receiver holds off; the sender keeps offering until the input stalls.
      hold_words = 1'b1;
      steady     = 1'b1;
      offer_random(30);
      steady = 1'b0;
      wait_words_drained();

      offer_random(RANDOM_ITEMS - 210);

      wait_words_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (word_board.mismatches == 0 && word_board.pending() == 0) begin
         $display("** number_to_english_word_tokens: PASSED **");
      end else begin
         $display("** number_to_english_word_tokens: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
